@@ rtl/nfsa_pkg.sv @@
package nfsa_pkg;

  localparam int WORD_W    = 64;
  localparam int OFF_W     = 6;
  localparam int SLOT_W    = 12;
  localparam int SLOT_SPAN = 4096;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

endpackage

@@ rtl/next_free_slot_allocator.sv @@
// A request gets the lowest free slot at or above it, scanning map words upward from its own;
// one beyond the map gets no_free at once. The map holds WORDS = min(SLOTS,4096)/64 rounded
// up (64 words at 4096 slots); one 64-bit map word is scanned per cycle. A new request is taken only while idle.
// The output register lets a new request start while a result waits.
// Reset (rst_ni low, asynchronous) frees every slot at once through per-word
// valid bits; the block comes out of reset idle and ready.
module next_free_slot_allocator #(
  parameter int SLOTS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [11:0] req_value
  input  logic [nfsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [11:0] granted_slot, [12] no_free
  output logic [nfsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import nfsa_pkg::*;

  localparam int LIMIT = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;
  localparam int WORDS = (LIMIT + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LAST  = WORDS - 1;
  localparam int TAIL  = LIMIT % WORD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     word_q, word_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic              first_q, first_d;
  logic              rd_valid_q;
  logic [WORDS-1:0]  valid_q, valid_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_nf_q, res_nf_d;
  logic              m_valid_q, m_valid_d;
  logic [SLOT_W-1:0] m_slot_q;
  logic              m_nf_q;
  logic              load_out;

  logic [SLOT_W-1:0] req;
  logic              s_fire;
  logic              req_over;
  logic [AW-1:0]     req_word;
  logic [AW-1:0]     rd_addr;
  logic              is_last;

  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] raw_word;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] tail_mask;
  logic [WORD_W-1:0] scan_word;
  logic              ffz_found;
  logic [OFF_W-1:0]  ffz_idx;
  logic              we;
  logic [WORD_W-1:0] wdata;

  assign req      = s_axis_tdata_i[SLOT_W-1:0];
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign req_over = {1'b0, req} >= (SLOT_W + 1)'(LIMIT);
  assign req_word = AW'(req[SLOT_W-1:OFF_W]);
  assign is_last  = word_q == AW'(LAST);

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({m_nf_q, m_slot_q});

  assign raw_word  = rd_valid_q ? ram_rdata : '0;
  assign lo_mask   = first_q ? ((WORD_W'(1) << off_q) - WORD_W'(1)) : '0;
  assign tail_mask = (TAIL != 0 && is_last) ?
                     ~((WORD_W'(1) << TAIL) - WORD_W'(1)) : '0;
  assign scan_word = raw_word | lo_mask | tail_mask;
  assign wdata     = raw_word | (WORD_W'(1) << ffz_idx);

  nfsa_ffz u_ffz (
    .word_i  (scan_word),
    .found_o (ffz_found),
    .idx_o   (ffz_idx)
  );

  nfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (word_q),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    word_d     = word_q;
    off_d      = off_q;
    first_d    = first_q;
    valid_d    = valid_q;
    res_slot_d = res_slot_q;
    res_nf_d   = res_nf_q;
    we         = 1'b0;
    rd_addr    = word_q;
    load_out   = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    case (state_q)
      S_IDLE: begin
        rd_addr = req_word;
        if (s_fire) begin
          word_d  = req_word;
          off_d   = req[OFF_W-1:0];
          first_d = 1'b1;
          if (req_over) begin
            res_slot_d = '0;
            res_nf_d   = 1'b1;
            state_d    = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = is_last ? word_q : word_q + AW'(1);
        first_d = 1'b0;
        if (ffz_found) begin
          we               = 1'b1;
          valid_d[word_q]  = 1'b1;
          res_slot_d       = SLOT_W'({word_q, ffz_idx});
          res_nf_d         = 1'b0;
          state_d          = S_DONE;
        end else if (is_last) begin
          res_slot_d = '0;
          res_nf_d   = 1'b1;
          state_d    = S_DONE;
        end else begin
          word_d = word_q + AW'(1);
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      rd_valid_q <= valid_q[rd_addr];
      m_valid_q  <= m_valid_d;
      first_q    <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    off_q      <= off_d;
    res_slot_q <= res_slot_d;
    res_nf_q   <= res_nf_d;
    if (load_out) begin
      m_slot_q <= res_slot_q;
      m_nf_q   <= res_nf_q;
    end
  end

endmodule

@@ rtl/nfsa_ram.sv @@
module nfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/nfsa_ffz.sv @@
module nfsa_ffz (
  input  logic [nfsa_pkg::WORD_W-1:0] word_i,
  output logic                        found_o,
  output logic [nfsa_pkg::OFF_W-1:0]  idx_o
);
  import nfsa_pkg::*;

  always_comb begin
    idx_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        idx_o = OFF_W'(i);
      end
    end
    found_o = ~&word_i;
  end

endmodule

@@ rtl/nfsa_chk.sv @@
module nfsa_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [nfsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [nfsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import nfsa_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_nofree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[SLOT_W] |-> m_axis_tdata_o[SLOT_W-1:0] == '0)
    else $error("no_free result carries a nonzero slot");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready stayed high after a request transaction");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:SLOT_W+1] == '0)
    else $error("result padding bits not zero");

endmodule

bind next_free_slot_allocator nfsa_chk u_nfsa_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ dv/next_free_slot_allocator_tb.sv @@
module next_free_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfsa_pkg::*;

  localparam int NUM_RAND   = 1150;
  localparam int CYCLE_MAX  = 1000000;
  localparam int DRAIN_CYC  = 80;

  localparam logic [SLOT_W-1:0] DIRECTED_REQS [22] = '{
    12'd0, 12'd0, 12'd1, 12'd4095, 12'd4095, 12'd4094, 12'd4094, 12'd4093,
    12'd63, 12'd63, 12'd64, 12'd127, 12'd128, 12'd2048, 12'd2048, 12'd2047,
    12'hAAA, 12'h555, 12'd4032, 12'd4032, 12'd4031, 12'hFFF
  };

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              no_free;
  } grant_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  logic [SLOT_W-1:0] req_q[$];
  grant_t            grant_q[$];
  logic [SLOT_SPAN-1:0] slot_map;

  logic        in_taken;
  logic [SLOT_W-1:0] next_req;
  int          total_reqs;
  int          n_sent;
  int          n_grants;
  int          n_full;
  int          n_errors;
  int          cycle_cnt;

  next_free_slot_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Lowest free slot at or above the request; mark it used.
  function automatic grant_t predict_grant(input logic [SLOT_W-1:0] req);
    grant_t g;
    g.slot    = '0;
    g.no_free = 1'b1;
    for (int s = req; s < SLOT_SPAN; s++) begin
      if (!slot_map[s]) begin
        slot_map[s] = 1'b1;
        g.slot    = SLOT_W'(s);
        g.no_free = 1'b0;
        break;
      end
    end
    return g;
  endfunction

  function automatic int sender_idle_pct();
    int ph;
    ph = (n_sent * 3) / (total_reqs > 0 ? total_reqs : 1);
    return (ph == 0) ? 30 : (ph == 1) ? 54 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int ph;
    ph = (n_sent * 3) / (total_reqs > 0 ? total_reqs : 1);
    return (ph == 0) ? 54 : (ph == 1) ? 30 : 0;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (req_q.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
          next_req = req_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {{(IN_TDATA_W-SLOT_W){1'b0}}, next_req};
          n_sent++;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= receiver_idle_pct());
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
      slot_map = '0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      in_taken  <= s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=0x%0h", m_axis_tdata_o));
        end else begin
          automatic grant_t exp_g = grant_q.pop_front();
          if (m_axis_tdata_o[SLOT_W-1:0] !== exp_g.slot)
            report_mismatch($sformatf("granted_slot got %0d exp %0d",
                                      m_axis_tdata_o[SLOT_W-1:0], exp_g.slot));
          if (m_axis_tdata_o[SLOT_W] !== exp_g.no_free)
            report_mismatch($sformatf("no_free got %b exp %b (slot exp %0d)",
                                      m_axis_tdata_o[SLOT_W], exp_g.no_free, exp_g.slot));
          if (exp_g.no_free) n_full++;
          else n_grants++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        grant_q.push_back(predict_grant(s_axis_tdata_i[SLOT_W-1:0]));
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_MAX);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("next_free_slot_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    int base;
    int sel;
    int v;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cycle_cnt       = 0;
    n_sent          = 0;
    n_grants        = 0;
    n_full          = 0;
    n_errors        = 0;
    base            = 0;

    // slot zero, top of map, word boundaries, repeated requests
    foreach (DIRECTED_REQS[i])
      req_q.push_back(DIRECTED_REQS[i]);

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i % 16 == 0) base = $urandom_range(4095, 0);
      sel = $urandom_range(99, 0);
      if (sel < 40) begin
        v = base + $urandom_range(31, 0);
        if (v > 4095) v = 4095;
      end else if (sel < 65) begin
        v = $urandom_range(4095, 3968);
      end else if (sel < 72) begin
        v = $urandom_range(15, 0);
      end else begin
        v = $urandom_range(4095, 0);
      end
      req_q.push_back(SLOT_W'(v));
    end
    total_reqs = req_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() > 0 || s_axis_tvalid_i || grant_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (grant_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", grant_q.size()));

    $display("sent %0d requests: %0d slots granted, %0d no_free answers",
             n_sent, n_grants, n_full);
    $display("slots used at end: %0d of %0d, mismatches: %0d",
             $countones(slot_map), SLOT_SPAN, n_errors);
    if (n_errors == 0) begin
      $display("next_free_slot_allocator_tb: PASS");
    end else begin
      $display("next_free_slot_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
